[src/pap_pkg.sv]
// package for the polygon area / perimeter unit
// holds widths, the controller state type, operation codes and helpers
// no dependencies
package pap_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W = COORD_W + 1;
  localparam int MAG_W = 2 * DIFF_W;
  localparam int CROSS_W = MAG_W + 2;
  localparam int PROD_W = 2 * MAG_W;
  localparam int ROOT_W = PROD_W / 2;
  localparam int REM_W = ROOT_W + 2;
  localparam int MEAS_W = 48;
  localparam int ACC_W = MEAS_W + 1;
  localparam int EDGE_SHIFT = 16;
  localparam int MAX_FACE_VERTICES_DEF = 256;

  localparam logic [ACC_W-1:0] MEAS_OVER = {1'b1, {MEAS_W{1'b0}}};
  localparam logic [MEAS_W-1:0] MEAS_MAX = {MEAS_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_MUL_START,
    ST_MUL_WAIT,
    ST_SQRT_START,
    ST_SQRT_WAIT,
    ST_POST,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_X_POS,
    OP_X_NEG,
    OP_Y_POS,
    OP_Y_NEG,
    OP_Z_POS,
    OP_Z_NEG,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQ_Z
  } op_t;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [CROSS_W-1:0] x);
    logic [CROSS_W-1:0] a;
    a = x[CROSS_W-1] ? CROSS_W'(-x) : CROSS_W'(x);
    return a[MAG_W-1:0];
  endfunction

  function automatic logic signed [CROSS_W-1:0] ext_diff(input logic signed [DIFF_W-1:0] d);
    return {{(CROSS_W-DIFF_W){d[DIFF_W-1]}}, d};
  endfunction

endpackage

[src/polygon_area_perimeter_unit.sv]
// top level of the polygon area / perimeter unit: controller and accumulator
// depends on pap_pkg, pap_mul, pap_sqrt
//
// channel   direction  signals
// in_       input      in_valid/in_ready, vertex x/y/z, last_vertex
// out_      output     out_valid/out_ready, measurement, saturated
// cfg_      input      cfg_wr_en/cfg_wr_data, measure mode
//
// one item at a time; an edge takes 4 passes through the shared serial
// multiplier or the serial root, a fan triangle 10, the first vertex of a
// face none; a closing vertex adds an emit step, and one more edge in
// length mode
// reset is synchronous; the result waits in an output register and only
// a face that closes while it is still untaken holds the unit
module polygon_area_perimeter_unit #(
  parameter int MAX_FACE_VERTICES = pap_pkg::MAX_FACE_VERTICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [pap_pkg::COORD_W-1:0] in_vertex_x,
  input  logic signed [pap_pkg::COORD_W-1:0] in_vertex_y,
  input  logic signed [pap_pkg::COORD_W-1:0] in_vertex_z,
  input  logic                              in_last_vertex,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pap_pkg::MEAS_W-1:0]        out_measurement,
  output logic                              out_saturated,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data
);
  import pap_pkg::*;

  localparam int CNT_W = $clog2(MAX_FACE_VERTICES + 1);

  state_t state_r, state_nxt;
  op_t    op_r;

  logic signed [COORD_W-1:0] cur_r [3];
  logic signed [COORD_W-1:0] prev_r [3];
  logic signed [COORD_W-1:0] first_r [3];
  logic signed [CROSS_W-1:0] c_r [3];
  logic signed [DIFF_W-1:0]  u [3];
  logic signed [DIFF_W-1:0]  v [3];
  logic signed [DIFF_W-1:0]  dpc [3];
  logic signed [DIFF_W-1:0]  dcf [3];
  logic [PROD_W-1:0]         sumsq_r;
  logic [ACC_W-1:0]          acc_r, acc_sum;
  logic [CNT_W-1:0]          count_r, count_n;
  logic                      last_r, mode_r, cfg_mode_r, tri_r, closing_r;
  logic                      out_valid_r, out_sat_r;
  logic [MEAS_W-1:0]         out_meas_r;

  logic                      mul_start, mul_done, sqrt_start, sqrt_done, term_neg;
  logic [MAG_W-1:0]          mul_a, mul_b;
  logic [PROD_W-1:0]         mul_p;
  logic [ROOT_W-1:0]         root;
  logic signed [CROSS_W-1:0] sa, sb, p_term;
  logic [1:0]                dst;
  logic [ROOT_W-1:0]         contrib;
  logic [PROD_W-1:0]         radicand;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u[i] = DIFF_W'(prev_r[i]) - DIFF_W'(first_r[i]);
      v[i] = DIFF_W'(cur_r[i]) - DIFF_W'(first_r[i]);
      dpc[i] = DIFF_W'(prev_r[i]) - DIFF_W'(cur_r[i]);
      dcf[i] = DIFF_W'(cur_r[i]) - DIFF_W'(first_r[i]);
    end
  end

  // operand selection for the current product
  always_comb begin
    sa = c_r[0];
    sb = c_r[0];
    term_neg = 1'b0;
    dst = 2'd0;
    unique case (op_r)
      OP_X_POS: begin sa = ext_diff(u[1]); sb = ext_diff(v[2]); dst = 2'd0; end
      OP_X_NEG: begin sa = ext_diff(u[2]); sb = ext_diff(v[1]); dst = 2'd0; term_neg = 1'b1; end
      OP_Y_POS: begin sa = ext_diff(u[2]); sb = ext_diff(v[0]); dst = 2'd1; end
      OP_Y_NEG: begin sa = ext_diff(u[0]); sb = ext_diff(v[2]); dst = 2'd1; term_neg = 1'b1; end
      OP_Z_POS: begin sa = ext_diff(u[0]); sb = ext_diff(v[1]); dst = 2'd2; end
      OP_Z_NEG: begin sa = ext_diff(u[1]); sb = ext_diff(v[0]); dst = 2'd2; term_neg = 1'b1; end
      OP_SQ_X:  begin sa = c_r[0]; sb = c_r[0]; end
      OP_SQ_Y:  begin sa = c_r[1]; sb = c_r[1]; end
      OP_SQ_Z:  begin sa = c_r[2]; sb = c_r[2]; end
      default:  begin sa = c_r[0]; sb = c_r[0]; end
    endcase
    mul_a = mag_of(sa);
    mul_b = mag_of(sb);
  end

  always_comb begin
    p_term = (sa[CROSS_W-1] ^ sb[CROSS_W-1] ^ term_neg) ?
             -$signed(mul_p[CROSS_W-1:0]) : $signed(mul_p[CROSS_W-1:0]);
    radicand = tri_r ? sumsq_r : {sumsq_r[PROD_W-EDGE_SHIFT-1:0], {EDGE_SHIFT{1'b0}}};
    contrib = tri_r ? (root >> 1) : root;
    acc_sum = acc_r + ACC_W'(contrib);
    count_n = (count_r < CNT_W'(MAX_FACE_VERTICES)) ? count_r + 1'b1 : count_r;
  end

  pap_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  pap_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start), .radicand(radicand),
    .done(sqrt_done), .root(root)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:       if (in_valid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        priority if (count_r == '0) state_nxt = ST_POST;
        else if (mode_r) state_nxt = ST_MUL_START;
        else if (count_r >= CNT_W'(2)) state_nxt = ST_MUL_START;
        else state_nxt = ST_POST;
      end
      ST_MUL_START:  state_nxt = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) state_nxt = (op_r == OP_SQ_Z) ? ST_SQRT_START : ST_MUL_START;
      end
      ST_SQRT_START: state_nxt = ST_SQRT_WAIT;
      ST_SQRT_WAIT: begin
        if (sqrt_done) state_nxt = closing_r ? ST_EMIT : ST_POST;
      end
      ST_POST: begin
        priority if (!last_r) state_nxt = ST_IDLE;
        else if (mode_r && count_n > CNT_W'(2)) state_nxt = ST_MUL_START;
        else state_nxt = ST_EMIT;
      end
      ST_EMIT:       if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_ready = 1'b0;
    mul_start = 1'b0;
    sqrt_start = 1'b0;
    unique case (state_r)
      ST_IDLE:       in_ready = 1'b1;
      ST_MUL_START:  mul_start = 1'b1;
      ST_SQRT_START: sqrt_start = 1'b1;
      default:       ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cfg_mode_r <= 1'b0;
      out_valid_r <= 1'b0;
      count_r <= '0;
      acc_r <= '0;
      closing_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        first_r[i] <= '0;
        prev_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) cfg_mode_r <= cfg_wr_data;
      if (out_valid_r && out_ready && state_r != ST_EMIT) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_DISPATCH: begin
          closing_r <= 1'b0;
          if (count_r == '0) begin
            acc_r <= '0;
            for (int i = 0; i < 3; i++) first_r[i] <= cur_r[i];
          end
        end
        ST_SQRT_WAIT: begin
          if (sqrt_done) acc_r <= (acc_sum > MEAS_OVER) ? MEAS_OVER : acc_sum;
        end
        ST_POST: begin
          count_r <= count_n;
          for (int i = 0; i < 3; i++) prev_r[i] <= cur_r[i];
          if (last_r && mode_r && count_n > CNT_W'(2)) closing_r <= 1'b1;
        end
        ST_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            count_r <= '0;
            acc_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload and job registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      cur_r[0] <= in_vertex_x;
      cur_r[1] <= in_vertex_y;
      cur_r[2] <= in_vertex_z;
      last_r <= in_last_vertex;
      mode_r <= cfg_mode_r;
    end
    if (state_r == ST_DISPATCH) begin
      sumsq_r <= '0;
      if (mode_r) begin
        tri_r <= 1'b0;
        op_r <= OP_SQ_X;
        for (int i = 0; i < 3; i++) c_r[i] <= ext_diff(dpc[i]);
      end else begin
        tri_r <= 1'b1;
        op_r <= OP_X_POS;
        for (int i = 0; i < 3; i++) c_r[i] <= '0;
      end
    end
    if (state_r == ST_POST) begin
      sumsq_r <= '0;
      tri_r <= 1'b0;
      op_r <= OP_SQ_X;
      for (int i = 0; i < 3; i++) c_r[i] <= ext_diff(dcf[i]);
    end
    if (state_r == ST_MUL_WAIT && mul_done) begin
      if (op_r == OP_SQ_X || op_r == OP_SQ_Y || op_r == OP_SQ_Z) begin
        sumsq_r <= sumsq_r + mul_p;
      end else begin
        c_r[dst] <= c_r[dst] + p_term;
      end
      if (op_r != OP_SQ_Z) op_r <= op_t'(op_r + 1'b1);
    end
    if (state_r == ST_EMIT && (!out_valid_r || out_ready)) begin
      out_meas_r <= acc_r[MEAS_W] ? MEAS_MAX : acc_r[MEAS_W-1:0];
      out_sat_r <= acc_r[MEAS_W];
    end
  end

  assign out_valid = out_valid_r;
  assign out_measurement = out_meas_r;
  assign out_saturated = out_sat_r;

`ifndef SYNTH
  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= MEAS_OVER) else $error("accumulator beyond saturation bound");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_FACE_VERTICES)) else $error("vertex count overran");
  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> &out_measurement) else $error("saturated result not at max");
  a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == ST_MUL_WAIT) else $error("multiplier finished outside wait");
  a_sqrt_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> state_r == ST_SQRT_WAIT) else $error("root finished outside wait");
`endif

endmodule

[src/pap_mul.sv]
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on pap_pkg
module pap_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pap_pkg::MAG_W-1:0]   a,
  input  logic [pap_pkg::MAG_W-1:0]   b,
  output logic                        done,
  output logic [pap_pkg::PROD_W-1:0]  p
);
  import pap_pkg::*;

  localparam int CNT_W = $clog2(MAG_W);

  logic [MAG_W-1:0]  a_r;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [MAG_W:0]    sum;

  always_comb begin
    sum = {1'b0, prod_r[PROD_W-1:MAG_W]} + (prod_r[0] ? {1'b0, a_r} : '0);
    prod_nxt = {sum, prod_r[MAG_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MAG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      prod_r <= {{MAG_W{1'b0}}, b};
    end else if (busy_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign done = done_r;
  assign p = prod_r;

endmodule

[src/pap_sqrt.sv]
// restoring integer square root, one root bit per cycle
// depends on pap_pkg
module pap_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pap_pkg::PROD_W-1:0]  radicand,
  output logic                        done,
  output logic [pap_pkg::ROOT_W-1:0]  root
);
  import pap_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);

  logic [PROD_W-1:0] rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [REM_W+1:0]  r2, trial, diff;

  always_comb begin
    r2 = {rem_r, rad_r[PROD_W-1:PROD_W-2]};
    trial = {2'b00, root_r, 2'b01};
    diff = r2 - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r <= radicand;
      rem_r <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[PROD_W-3:0], 2'b00};
      if (r2 >= trial) begin
        rem_r <= diff[REM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r <= r2[REM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
